// ===== hdl/unsigned_binary_divider_assert.svh =====
// ----------------------------------------------------------------------------
// unsigned_binary_divider_assert.svh
// Assertion macros used by the divider checker.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_BINARY_DIVIDER_ASSERT_SVH
`define UNSIGNED_BINARY_DIVIDER_ASSERT_SVH

// ante at one edge implies cons at the next edge
`define UBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// ante implies cons at the same edge
`define UBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ubd_pkg.sv =====
// ----------------------------------------------------------------------------
// ubd_pkg
// Shared widths and the per-cell payload type of the unsigned divider.
// ----------------------------------------------------------------------------
`default_nettype none

package ubd_pkg;

   localparam int WIDTH  = 32;
   localparam int DATA_W = 2 * WIDTH;

   // acc: dividend bits still to enter (high) and quotient bits so far (low)
   typedef struct packed {
      logic [WIDTH-1:0] rem;
      logic [WIDTH-1:0] acc;
      logic [WIDTH-1:0] den;
   } ubd_stage_type;

endpackage

`default_nettype wire

// ===== hdl/unsigned_binary_divider.sv =====
// ----------------------------------------------------------------------------
// unsigned_binary_divider
// Pipelined radix-2 restoring divider, one cell per quotient bit.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)              purpose
//  req      in   dividend[31:0], divisor[31:0]   operands
//  rsp      out  quotient[31:0], remainder[31:0] results
//
//  One transfer per cycle sustained in both directions while rsp_tready is high.
//  Items pass through a row of WIDTH registered cells, one quotient bit each.
//  Every cell holds its item while the next one is not ready, so a stalled
//  rsp side backs up cell by cell and req_tready drops once the row is full.
//  Reset clears the cell valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_binary_divider import ubd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,   // dividend, divisor
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata    // quotient, remainder
);

   logic          stage_valid [0:WIDTH];
   logic          stage_ready [0:WIDTH];
   ubd_stage_type stage_data  [0:WIDTH];

   assign stage_valid[0]    = req_tvalid;
   assign req_tready        = stage_ready[0];
   assign stage_data[0].rem = '0;
   assign stage_data[0].acc = req_tdata[WIDTH-1:0];
   assign stage_data[0].den = req_tdata[DATA_W-1:WIDTH];

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      ubd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_stage  (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_stage (stage_data[i+1])
      );
   end

   assign stage_ready[WIDTH] = rsp_tready;
   assign rsp_tvalid         = stage_valid[WIDTH];
   assign rsp_tdata          = {stage_data[WIDTH].rem, stage_data[WIDTH].acc};

endmodule

`default_nettype wire

// ===== hdl/ubd_cell.sv =====
// ----------------------------------------------------------------------------
// ubd_cell
// One shift-and-subtract step of the divider with its own pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none

module ubd_cell import ubd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire ubd_stage_type in_stage,
   output logic               out_valid,
   input  wire logic          out_ready,
   output ubd_stage_type      out_stage
);

   logic          valid_ff;
   logic          valid_in;
   ubd_stage_type stage_ff;
   ubd_stage_type stage_in;
   logic [WIDTH-1:0] trial;
   logic [WIDTH-1:0] diff;
   logic             take;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      trial = {in_stage.rem[WIDTH-2:0], in_stage.acc[WIDTH-1]};
      diff  = trial - in_stage.den;
      take  = in_stage.rem[WIDTH-1] || (trial >= in_stage.den);
      stage_in.rem = take ? diff : trial;
      stage_in.acc = {in_stage.acc[WIDTH-2:0], take};
      stage_in.den = in_stage.den;
   end

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

// ===== hdl/ubd_checker.sv =====
// ----------------------------------------------------------------------------
// ubd_checker
// Port-level checks of the divider, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unsigned_binary_divider_assert.svh"

module ubd_checker import ubd_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [DATA_W-1:0] rsp_tdata
);

   `UBD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result after reset")

   `UBD_ASSERT_NOW(a_accept_free, clock, reset, (!rsp_tvalid || rsp_tready) && req_tvalid,
      req_tready, "input refused with free output")

   `UBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "result dropped while stalled")

   `UBD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready,
      $stable(rsp_tdata), "result changed while stalled")

endmodule

bind unsigned_binary_divider ubd_checker u_ubd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pipelined unsigned divider. Drives operand
// pairs on the req stream and predicts each quotient and remainder with a
// bit-serial restoring division. Compares every rsp transfer in order with
// the oldest prediction. Runs a directed set first, then random operands of
// mixed bit lengths under three idle patterns. Long rsp stalls back up the
// row and drop req_tready.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ubd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_CYCLES  = 300;

   typedef logic [WIDTH-1:0] word_type;

   typedef struct packed {
      word_type quotient;
      word_type remainder;
   } division_result_type;

   class division_scoreboard;
      division_result_type expected_q[$];
      int                  error_count;

      function new();
         error_count = 0;
      endfunction

      function division_result_type divide(word_type num, word_type den);
         logic [WIDTH:0]      partial;
         division_result_type r;
         partial    = '0;
         r.quotient = '0;
         for (int i = WIDTH - 1; i >= 0; i--) begin
            partial    = {partial[WIDTH-1:0], num[i]};
            r.quotient = r.quotient << 1;
            if (partial >= {1'b0, den}) begin
               partial       = partial - {1'b0, den};
               r.quotient[0] = 1'b1;
            end
         end
         r.remainder = partial[WIDTH-1:0];
         return r;
      endfunction

      function void add_operands(word_type dividend, word_type divisor);
         expected_q.push_back(divide(dividend, divisor));
      endfunction

      function void check_result(word_type quotient, word_type remainder);
         division_result_type exp_r;
         if (expected_q.size() == 0) begin
            $error("unexpected result: quotient %h, remainder %h", quotient, remainder);
            error_count++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (quotient !== exp_r.quotient) begin
            $error("quotient: expected %h, got %h", exp_r.quotient, quotient);
            error_count++;
         end
         if (remainder !== exp_r.remainder) begin
            $error("remainder: expected %h, got %h", exp_r.remainder, remainder);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata   = '0;   // dividend, divisor
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;          // quotient, remainder

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int results_seen  = 0;
   int hold_left     = 0;
   int cycles        = 0;

   division_scoreboard quotient_board = new();

   unsigned_binary_divider u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   // check results; stall the rsp side at random and for long stretches
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            quotient_board.check_result(rsp_tdata[WIDTH-1:0], rsp_tdata[DATA_W-1:WIDTH]);
            results_seen++;
            if (results_seen == 200 || results_seen == 650)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_division(input word_type dividend, input word_type divisor);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {divisor, dividend};
      do @(posedge clock); while (!req_tready);
      quotient_board.add_operands(dividend, divisor);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (quotient_board.pending() != 0) @(posedge clock);
   endtask

   function automatic word_type random_operand();
      word_type value;
      int       span;
      value = $urandom;
      span  = $urandom_range(1, WIDTH);
      return value & ({WIDTH{1'b1}} >> (WIDTH - span));
   endfunction

   initial begin
      word_type dividend;
      word_type divisor;
      word_type all_ones;
      word_type top_bit;
      all_ones = '1;
      top_bit  = word_type'(1) << (WIDTH - 1);

      while (reset) @(posedge clock);

      send_division('0, '0);
      send_division(all_ones, '0);
      send_division(32'd12345, '0);
      send_division('0, all_ones);
      send_division(all_ones, all_ones);
      send_division(all_ones, 32'd1);
      send_division(32'd1, all_ones);
      send_division(top_bit, 32'd1);
      send_division(all_ones, top_bit);
      send_division(top_bit, top_bit);
      send_division(all_ones, all_ones >> 1);
      send_division(all_ones >> 1, all_ones);
      send_division(all_ones, 32'd2);
      send_division(32'd100, 32'd7);
      send_division(32'd7, 32'd100);
      send_division(32'd5, 32'd5);
      send_division(32'd1, 32'd1);
      send_division(32'hAAAA_AAAA, 32'h5555_5555);
      send_division(32'h5555_5555, 32'hAAAA_AAAA);
      send_division(top_bit - 1, top_bit);
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 0) begin
            send_idle_pct = 36;
            recv_idle_pct <= 71;
         end else if (n == RANDOM_ITEMS / 3) begin
            drain_results();
            send_idle_pct = 71;
            recv_idle_pct <= 36;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         dividend = random_operand();
         case ($urandom_range(9))
            0: divisor = '0;
            1: divisor = dividend + word_type'($urandom_range(1, 3));
            2: begin
               divisor  = random_operand() | 1'b1;
               dividend = divisor * word_type'($urandom_range(0, 1000));
            end
            default: divisor = random_operand();
         endcase
         send_division(dividend, divisor);
      end
      req_tvalid <= 1'b0;

      while (quotient_board.pending() != 0) @(posedge clock);
      repeat (2 * WIDTH + 8) @(posedge clock);
      if (quotient_board.error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ubd_pkg.sv
hdl/ubd_cell.sv
hdl/unsigned_binary_divider.sv
hdl/ubd_checker.sv
sim/testbench.sv
